// ===== sv/psrr_pkg.sv =====
package psrr_pkg;

	localparam int DEF_MAX_RADIUS = 31;
	localparam int DEF_MAX_LINE   = 4096;
	localparam int DEF_KEY_WIDTH  = 16;
	localparam int QUEUE_DEPTH    = 4;

	localparam int FIELD_W    = 12;
	localparam int LIDX_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DESCEND   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd6;

	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_BAND   = 2'd1;
	localparam logic [1:0] MODE_WAVES  = 2'd2;
	localparam logic [1:0] MODE_RANDOM = 2'd3;

	localparam logic [31:0] MIX_MUL1 = 32'h7feb352d;
	localparam logic [31:0] MIX_MUL2 = 32'h846ca68b;
	localparam logic [31:0] SEED_MUL = 32'h9e3779b9;
	localparam logic [31:0] POS_MUL  = 32'h85ebca6b;
	localparam logic [31:0] RUN_MUL  = 32'hc2b2ae35;
	localparam logic [12:0] ONE_FIXED = 13'd4096;

	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] length;
		logic [12:0] band_low;
		logic [12:0] band_high;
		logic [23:0] threshold;
		logic        descending;
		logic [4:0]  radius;
	} cfg_t;

endpackage

// ===== sv/psrr_ram.sv =====
module psrr_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/psrr_div.sv =====
// Restoring divider, one quotient bit a cycle. Short mode divides a QW-bit value.
module psrr_div #(
	parameter int QW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          long_mode,
	input  logic [31:0]   num,
	input  logic [11:0]   den,
	output logic          busy,
	output logic [QW-1:0] quot,
	output logic [11:0]   rem
);
	logic [31:0]   num_q;
	logic [11:0]   rem_q;
	logic [QW-1:0] quot_q;
	logic [5:0]    cnt_q;
	logic [12:0]   trial;
	logic          fits;

	assign trial = {rem_q, num_q[31]};
	assign fits  = trial >= {1'b0, den};
	assign busy  = cnt_q != 6'd0;
	assign quot  = quot_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= long_mode ? 6'd32 : 6'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= long_mode ? num : {num[QW-1:0], {(32-QW){1'b0}}};
			rem_q  <= 12'd0;
			quot_q <= '0;
		end else if (busy) begin
			num_q  <= {num_q[30:0], 1'b0};
			rem_q  <= fits ? 12'(trial - {1'b0, den}) : trial[11:0];
			quot_q <= {quot_q[QW-2:0], fits};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy)
		else $error("divider restarted while busy");
endmodule

// ===== sv/psrr_front.sv =====
// Classifies each key as wall or sortable and queues it.
module psrr_front #(
	parameter int KEY_WIDTH = 16,
	parameter int MAX_LINE  = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  psrr_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [KEY_WIDTH-1:0]             in_key,
	input  logic [psrr_pkg::LIDX_W-1:0]      in_lidx,
	input  logic                             in_last,
	output logic                             q_push,
	input  logic                             q_full,
	output logic [KEY_WIDTH+1:0]             q_data
);
	import psrr_pkg::*;

	localparam int POS_W = $clog2(MAX_LINE);

	localparam logic [3:0] F_IDLE = 4'd0;
	localparam logic [3:0] F_SEED = 4'd1;
	localparam logic [3:0] F_MA   = 4'd2;
	localparam logic [3:0] F_MB   = 4'd3;
	localparam logic [3:0] F_MH   = 4'd4;
	localparam logic [3:0] F_DIVP = 4'd5;
	localparam logic [3:0] F_WDIV = 4'd6;
	localparam logic [3:0] F_PUSH = 4'd7;

	localparam logic [1:0] P_SEED = 2'd0;
	localparam logic [1:0] P_WALL = 2'd1;
	localparam logic [1:0] P_DROP = 2'd2;

	logic [3:0]           state_q;
	logic [1:0]           purp_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [LIDX_W-1:0]    lidx_q;
	logic                 last_q;
	logic                 sortable_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     run_q;
	logic [11:0]          off_q;
	logic [31:0]          seed_q;
	logic [31:0]          mul_q;

	logic [31:0]      mul_a, mul_b, pre, hash;
	logic [63:0]      prod;
	logic             mul_en;
	logic             div_start, div_long, div_busy;
	logic [31:0]      div_num;
	logic [POS_W-1:0] div_quot;
	logic [11:0]      div_rem;
	logic [11:0]      len;
	logic             drop_go, in_band, wall_hit;
	logic [12:0]      key_c, band_a, band_b, band_lo, band_hi;

	assign len     = (cfg.length < 12'd2) ? 12'd2 : cfg.length;
	assign drop_go = cfg.threshold != 24'd0;
	assign pre     = (purp_q == P_SEED) ? mul_q : (seed_q ^ mul_q);
	assign hash    = mul_q ^ (mul_q >> 16);
	assign prod    = mul_a * mul_b;

	// band test works on the key clamped to one
	assign key_c   = (32'(key_q) > 32'(ONE_FIXED)) ? ONE_FIXED : 13'(key_q);
	assign band_a  = (cfg.band_low > ONE_FIXED) ? ONE_FIXED : cfg.band_low;
	assign band_b  = (cfg.band_high > ONE_FIXED) ? ONE_FIXED : cfg.band_high;
	assign band_lo = (band_a < band_b) ? band_a : band_b;
	assign band_hi = (band_a < band_b) ? band_b : band_a;
	assign in_band = !(key_c < band_lo || key_c > band_hi);

	assign wall_hit = (cfg.mode == MODE_WAVES) ? (off_q == div_rem) : (div_rem == 12'd0);

	assign in_ready = state_q == F_IDLE;
	assign q_push   = (state_q == F_PUSH) && !q_full;
	assign q_data   = {last_q, sortable_q, key_q};

	psrr_div #(.QW(POS_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.long_mode (div_long),
		.num       (div_num),
		.den       (len),
		.busy      (div_busy),
		.quot      (div_quot),
		.rem       (div_rem)
	);

	always_comb begin
		mul_en    = 1'b0;
		mul_a     = 32'd0;
		mul_b     = 32'd0;
		div_start = 1'b0;
		div_long  = 1'b0;
		div_num   = 32'd0;
		case (state_q)
			F_IDLE: begin
				div_start = in_valid;
				div_num   = 32'(pos_q);
			end
			F_SEED: begin
				mul_en = 1'b1;
				mul_a  = 32'(lidx_q);
				mul_b  = SEED_MUL;
			end
			F_MA: begin
				mul_en = 1'b1;
				mul_a  = pre ^ (pre >> 16);
				mul_b  = MIX_MUL1;
			end
			F_MB: begin
				mul_en = 1'b1;
				mul_a  = mul_q ^ (mul_q >> 15);
				mul_b  = MIX_MUL2;
			end
			F_MH: begin
				if (purp_q == P_WALL) begin
					div_start = 1'b1;
					div_long  = 1'b1;
					div_num   = hash;
				end
			end
			F_DIVP: begin
				if (!div_busy) begin
					case (cfg.mode)
						MODE_BAND: begin
							mul_en = in_band && drop_go;
							mul_a  = 32'(div_quot);
							mul_b  = RUN_MUL;
						end
						MODE_WAVES: begin
							div_start = 1'b1;
							div_long  = 1'b1;
							div_num   = seed_q;
						end
						MODE_RANDOM: begin
							mul_en = 1'b1;
							mul_a  = 32'(pos_q);
							mul_b  = POS_MUL;
						end
						default: begin
							mul_en = drop_go;
							mul_b  = RUN_MUL;
						end
					endcase
				end
			end
			F_WDIV: begin
				if (!div_busy) begin
					mul_en = !wall_hit && drop_go;
					mul_a  = 32'(run_q);
					mul_b  = RUN_MUL;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= prod[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			purp_q     <= P_SEED;
			pos_q      <= '0;
			seed_q     <= 32'd0;
			run_q      <= '0;
			off_q      <= 12'd0;
			last_q     <= 1'b0;
			sortable_q <= 1'b0;
			key_q      <= '0;
			lidx_q     <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						key_q   <= in_key;
						lidx_q  <= in_lidx;
						last_q  <= in_last || (pos_q == POS_W'(MAX_LINE - 1));
						purp_q  <= P_SEED;
						state_q <= (pos_q == '0) ? F_SEED : F_DIVP;
					end
				end
				F_SEED: state_q <= F_MA;
				F_MA:   state_q <= F_MB;
				F_MB:   state_q <= F_MH;
				F_MH: begin
					case (purp_q)
						P_SEED: begin
							seed_q  <= hash;
							state_q <= F_DIVP;
						end
						P_WALL: state_q <= F_WDIV;
						default: begin
							sortable_q <= !(hash[23:0] < cfg.threshold);
							state_q    <= F_PUSH;
						end
					endcase
				end
				F_DIVP: begin
					if (!div_busy) begin
						run_q <= (cfg.mode == MODE_NONE) ? '0 : div_quot;
						off_q <= div_rem;
						case (cfg.mode)
							MODE_BAND: begin
								if (!in_band || !drop_go) begin
									sortable_q <= in_band;
									state_q    <= F_PUSH;
								end else begin
									purp_q  <= P_DROP;
									state_q <= F_MA;
								end
							end
							MODE_WAVES: state_q <= F_WDIV;
							MODE_RANDOM: begin
								purp_q  <= P_WALL;
								state_q <= F_MA;
							end
							default: begin
								if (drop_go) begin
									purp_q  <= P_DROP;
									state_q <= F_MA;
								end else begin
									sortable_q <= 1'b1;
									state_q    <= F_PUSH;
								end
							end
						endcase
					end
				end
				F_WDIV: begin
					if (!div_busy) begin
						if (wall_hit || !drop_go) begin
							sortable_q <= !wall_hit;
							state_q    <= F_PUSH;
						end else begin
							purp_q  <= P_DROP;
							state_q <= F_MA;
						end
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						pos_q   <= last_q ? '0 : pos_q + POS_W'(1);
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/psrr_queue.sv =====
module psrr_queue #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = count_q == (PTR_W+1)'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
endmodule

// ===== sv/psrr_back.sv =====
// Holds the key window and ranks each position against its run neighbours.
module psrr_back #(
	parameter int KEY_WIDTH  = 16,
	parameter int MAX_RADIUS = 31,
	parameter int MAX_LINE   = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  psrr_pkg::cfg_t               cfg,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  logic [KEY_WIDTH+1:0]         q_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [psrr_pkg::FIELD_W-1:0] out_position,
	output logic [psrr_pkg::FIELD_W-1:0] out_destination,
	output logic                         out_done
);
	import psrr_pkg::*;

	localparam int WIN    = 2 * MAX_RADIUS + 1;
	localparam int SLOT_W = $clog2(WIN);
	localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
	localparam int RANK_W = $clog2(2 * MAX_RADIUS + 1);
	localparam int POS_W  = $clog2(MAX_LINE);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WIN - 1);

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_CHECK = 4'd1;
	localparam logic [3:0] B_RSELF = 4'd2;
	localparam logic [3:0] B_USELF = 4'd3;
	localparam logic [3:0] B_RBK   = 4'd4;
	localparam logic [3:0] B_UBK   = 4'd5;
	localparam logic [3:0] B_FWD   = 4'd6;
	localparam logic [3:0] B_RFW   = 4'd7;
	localparam logic [3:0] B_UFW   = 4'd8;
	localparam logic [3:0] B_DONE  = 4'd9;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_LAST : s - SLOT_W'(1);
	endfunction

	logic [3:0]           state_q;
	logic [POS_W-1:0]     wr_pos_q;
	logic [SLOT_W-1:0]    wr_slot_q;
	logic                 last_q;
	logic [POS_W:0]       emit_q;
	logic [SLOT_W-1:0]    emit_slot_q;
	logic [POS_W-1:0]     cur_q;
	logic [SLOT_W-1:0]    cur_slot_q;
	logic [RAD_W-1:0]     cnt_q;
	logic [KEY_WIDTH-1:0] self_key_q;
	logic [POS_W-1:0]     head_q, tail_q;
	logic [RANK_W-1:0]    rank_q;
	logic                 out_valid_q;

	logic [KEY_WIDTH:0]   rdata;
	logic [KEY_WIDTH-1:0] rd_key;
	logic                 rd_sort;
	logic                 ram_re;
	logic [SLOT_W-1:0]    ram_raddr;
	logic [5:0]           sr6;
	logic [RAD_W-1:0]     r;
	logic [POS_W+1:0]     reach;
	logic                 emit_ok, load, emit_is_end;
	logic [POS_W-1:0]     emit_pos, dest;

	assign sr6 = 6'(cfg.radius);
	assign r   = RAD_W'((sr6 == 6'd0) ? 6'd1 :
		((sr6 > 6'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : sr6));

	assign emit_pos    = emit_q[POS_W-1:0];
	assign emit_is_end = emit_q == {1'b0, wr_pos_q};
	assign reach       = (POS_W+2)'(emit_q) + (POS_W+2)'(r);
	assign emit_ok     = (emit_q <= {1'b0, wr_pos_q}) &&
		(last_q || reach <= (POS_W+2)'(wr_pos_q));

	assign rd_key  = rdata[KEY_WIDTH-1:0];
	assign rd_sort = rdata[KEY_WIDTH];

	assign q_pop     = (state_q == B_IDLE) && q_valid;
	assign ram_re    = (state_q == B_RSELF) || (state_q == B_RBK) || (state_q == B_RFW);
	assign ram_raddr = (state_q == B_RSELF) ? emit_slot_q : cur_slot_q;
	assign load      = (state_q == B_DONE) && (!out_valid_q || out_ready);
	assign dest      = cfg.descending ? tail_q - POS_W'(rank_q) : head_q + POS_W'(rank_q);
	assign out_valid = out_valid_q;

	psrr_ram #(.WIDTH(KEY_WIDTH + 1), .DEPTH(WIN)) u_window (
		.clk   (clk),
		.we    (q_pop),
		.waddr (wr_slot_q),
		.wdata (q_data[KEY_WIDTH:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (load) begin
			out_position    <= FIELD_W'(emit_pos);
			out_destination <= FIELD_W'(dest);
			out_done        <= last_q && emit_is_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			wr_pos_q    <= '0;
			wr_slot_q   <= '0;
			last_q      <= 1'b0;
			emit_q      <= '0;
			emit_slot_q <= '0;
			cur_q       <= '0;
			cur_slot_q  <= '0;
			cnt_q       <= '0;
			self_key_q  <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						last_q  <= q_data[KEY_WIDTH+1];
						state_q <= B_CHECK;
					end
				end
				B_CHECK: begin
					if (emit_ok) begin
						state_q <= B_RSELF;
					end else begin
						if (last_q) begin
							wr_pos_q    <= '0;
							wr_slot_q   <= '0;
							emit_q      <= '0;
							emit_slot_q <= '0;
						end else begin
							wr_pos_q  <= wr_pos_q + POS_W'(1);
							wr_slot_q <= slot_inc(wr_slot_q);
						end
						state_q <= B_IDLE;
					end
				end
				B_RSELF: state_q <= B_USELF;
				B_USELF: begin
					self_key_q <= rd_key;
					rank_q     <= '0;
					head_q     <= emit_pos;
					tail_q     <= emit_pos;
					if (!rd_sort) begin
						state_q <= B_DONE;
					end else if (emit_q == '0) begin
						state_q <= B_FWD;
					end else begin
						cur_q      <= emit_pos - POS_W'(1);
						cur_slot_q <= slot_dec(emit_slot_q);
						cnt_q      <= RAD_W'(1);
						state_q    <= B_RBK;
					end
				end
				B_RBK: state_q <= B_UBK;
				B_UBK: begin
					if (!rd_sort) begin
						head_q  <= cur_q + POS_W'(1);
						state_q <= B_FWD;
					end else begin
						// ties on the left count as smaller
						if (rd_key <= self_key_q) begin
							rank_q <= rank_q + RANK_W'(1);
						end
						head_q <= cur_q;
						if (cnt_q == r || cur_q == '0) begin
							state_q <= B_FWD;
						end else begin
							cur_q      <= cur_q - POS_W'(1);
							cur_slot_q <= slot_dec(cur_slot_q);
							cnt_q      <= cnt_q + RAD_W'(1);
							state_q    <= B_RBK;
						end
					end
				end
				B_FWD: begin
					if (emit_is_end) begin
						state_q <= B_DONE;
					end else begin
						cur_q      <= emit_pos + POS_W'(1);
						cur_slot_q <= slot_inc(emit_slot_q);
						cnt_q      <= RAD_W'(1);
						state_q    <= B_RFW;
					end
				end
				B_RFW: state_q <= B_UFW;
				B_UFW: begin
					if (!rd_sort) begin
						tail_q  <= cur_q - POS_W'(1);
						state_q <= B_DONE;
					end else begin
						if (rd_key < self_key_q) begin
							rank_q <= rank_q + RANK_W'(1);
						end
						tail_q <= cur_q;
						if (cnt_q == r || cur_q == wr_pos_q) begin
							state_q <= B_DONE;
						end else begin
							cur_q      <= cur_q + POS_W'(1);
							cur_slot_q <= slot_inc(cur_slot_q);
							cnt_q      <= cnt_q + RAD_W'(1);
							state_q    <= B_RFW;
						end
					end
				end
				B_DONE: begin
					if (load) begin
						emit_q      <= emit_q + (POS_W+1)'(1);
						emit_slot_q <= slot_inc(emit_slot_q);
						state_q     <= B_CHECK;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_UBK || state_q == B_UFW) |-> (cnt_q != '0 && cnt_q <= r))
		else $error("scan step count out of radius");
	assert property (@(posedge clk) disable iff (!arst_n)
		rank_q <= RANK_W'(2 * MAX_RADIUS))
		else $error("rank beyond window");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CHECK) |-> (emit_q <= (POS_W+1)'(wr_pos_q) + (POS_W+1)'(1)))
		else $error("emit pointer ran past the newest position");
endmodule

// ===== sv/pixel_sort_run_rank_core.sv =====
// Front end: each key's position is divided (the line seed hides behind the divider), plus
//   a long division of the line seed for waves, a position hash and long division for
//   random walls and a run hash when run dropping is on; a new key is taken only once the
//   previous key is queued (one shared bit-serial divider). Back end: a result reads its key
//   and, if sortable, up to R neighbours each way; next keys are classified meanwhile via a
//   4-entry queue. A result stays registered until taken; reset (arst_n low, asynchronous)
//   clears all control state and the configuration registers to defaults.
module pixel_sort_run_rank_core #(
	parameter int MAX_RADIUS = psrr_pkg::DEF_MAX_RADIUS,
	parameter int MAX_LINE   = psrr_pkg::DEF_MAX_LINE,
	parameter int KEY_WIDTH  = psrr_pkg::DEF_KEY_WIDTH
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// key, line_index
	input  logic [((KEY_WIDTH+psrr_pkg::LIDX_W+7)/8)*8-1:0] s_axis_tdata,
	// last_in_line
	input  logic                                         s_axis_tlast,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// position, destination
	output logic [((2*psrr_pkg::FIELD_W+7)/8)*8-1:0]      m_axis_tdata,
	// line_done
	output logic                                         m_axis_tlast,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [psrr_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  logic [psrr_pkg::CFG_DATA_W-1:0]              cfg_data
);
	import psrr_pkg::*;

	localparam int OUT_W = ((2 * FIELD_W + 7) / 8) * 8;
	localparam int ENT_W = KEY_WIDTH + 2;

	cfg_t               cfg_q;
	logic               q_push, q_full, q_pop, q_empty;
	logic [ENT_W-1:0]   q_wdata, q_rdata;
	logic [FIELD_W-1:0] res_pos, res_dest;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = OUT_W'({res_dest, res_pos});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_NONE;
			cfg_q.length     <= 12'd2;
			cfg_q.band_low   <= 13'd0;
			cfg_q.band_high  <= ONE_FIXED;
			cfg_q.threshold  <= 24'd0;
			cfg_q.descending <= 1'b0;
			cfg_q.radius     <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:      cfg_q.mode       <= cfg_data[1:0];
				REG_LENGTH:    cfg_q.length     <= cfg_data[11:0];
				REG_BAND_LOW:  cfg_q.band_low   <= cfg_data[12:0];
				REG_BAND_HIGH: cfg_q.band_high  <= cfg_data[12:0];
				REG_THRESHOLD: cfg_q.threshold  <= cfg_data[23:0];
				REG_DESCEND:   cfg_q.descending <= cfg_data[0];
				REG_RADIUS:    cfg_q.radius     <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	psrr_front #(.KEY_WIDTH(KEY_WIDTH), .MAX_LINE(MAX_LINE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_key   (s_axis_tdata[KEY_WIDTH-1:0]),
		.in_lidx  (s_axis_tdata[KEY_WIDTH+LIDX_W-1:KEY_WIDTH]),
		.in_last  (s_axis_tlast),
		.q_push   (q_push),
		.q_full   (q_full),
		.q_data   (q_wdata)
	);

	psrr_queue #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	psrr_back #(
		.KEY_WIDTH  (KEY_WIDTH),
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_LINE   (MAX_LINE)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_valid         (!q_empty),
		.q_pop           (q_pop),
		.q_data          (q_rdata),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_position    (res_pos),
		.out_destination (res_dest),
		.out_done        (m_axis_tlast)
	);
endmodule
